// ===== hw/rtl/buffer_slice_handle_checker_top_assert.svh =====
// Assertion macros for the buffer slice handle checker.
// Used by the port checker; expects clk and arst_n in the including scope.
`ifndef BUFFER_SLICE_HANDLE_CHECKER_TOP_ASSERT_SVH
`define BUFFER_SLICE_HANDLE_CHECKER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BSHC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BSHC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/bshc_pkg.sv =====
// Package for the buffer slice handle checker: request and configuration types,
// status codes, register addresses and the handle decode function. No dependencies.
package bshc_pkg;

	localparam int unsigned SlotMsb = 23;
	localparam int unsigned GenLsb  = 24;
	localparam int unsigned GenMsb  = 47;
	localparam int unsigned KindLsb = 48;
	localparam int unsigned KindMsb = 55;
	localparam int unsigned LifeLsb = 56;
	localparam int unsigned LifeMsb = 59;
	localparam int unsigned RsvdLsb = 60;

	localparam int unsigned PaddrWidth = 4;
	localparam int unsigned OutTdataWidth = 8;

	localparam logic [1:0] RegKindFirst = 2'd0;
	localparam logic [1:0] RegKindLast  = 2'd1;
	localparam logic [1:0] RegLifeFirst = 2'd2;
	localparam logic [1:0] RegLifeLast  = 2'd3;

	localparam logic [7:0] KindFirstReset = 8'd0;
	localparam logic [7:0] KindLastReset  = 8'd3;
	localparam logic [3:0] LifeFirstReset = 4'd0;
	localparam logic [3:0] LifeLastReset  = 4'd2;

	typedef enum logic [3:0] {
		ST_VALID    = 4'd0,
		ST_HANDLE   = 4'd1,
		ST_KIND     = 4'd2,
		ST_SLOT     = 4'd3,
		ST_STALE    = 4'd4,
		ST_LIFETIME = 4'd5,
		ST_EXPIRED  = 4'd6,
		ST_EMPTY    = 4'd7,
		ST_OVERFLOW = 4'd8
	} status_t;

	// Last member lies in the lowest bits.
	typedef struct packed {
		logic [63:0] current_frame;
		logic [7:0]  expected_kind;
		logic [63:0] record_frame;
		logic [31:0] record_capacity;
		logic [63:0] record_handle;
		logic [31:0] slice_size;
		logic [31:0] slice_offset;
		logic [63:0] slice_handle;
	} req_t;

	localparam int unsigned InTdataWidth = $bits(req_t);

	typedef struct packed {
		logic [7:0] kind_first;
		logic [7:0] kind_last;
		logic [3:0] life_first;
		logic [3:0] life_last;
	} cfg_t;

	function automatic logic handle_ok(input logic [63:0] h, input cfg_t c);
		logic [7:0] kind;
		logic [3:0] life;
		kind = h[KindMsb:KindLsb];
		life = h[LifeMsb:LifeLsb];
		return (h != 64'd0) && (h[63:RsvdLsb] == '0) &&
			(h[SlotMsb:0] != '0) && (h[GenMsb:GenLsb] != '0) &&
			(kind >= c.kind_first) && (kind <= c.kind_last) &&
			(life >= c.life_first) && (life <= c.life_last);
	endfunction

endpackage

// ===== hw/rtl/bshc_eval.sv =====
// Status evaluation for one slice request against its buffer record.
// Depends on bshc_pkg for the request, configuration and status types.
module bshc_eval (
	input  bshc_pkg::req_t    req,
	input  bshc_pkg::cfg_t    cfg,
	output bshc_pkg::status_t status
);

	logic s_ok;
	logic r_ok;
	logic [7:0] s_kind;
	logic [7:0] r_kind;
	logic [3:0] s_life;
	logic [3:0] r_life;

	assign s_ok   = bshc_pkg::handle_ok(req.slice_handle, cfg);
	assign r_ok   = bshc_pkg::handle_ok(req.record_handle, cfg);
	assign s_kind = req.slice_handle[bshc_pkg::KindMsb:bshc_pkg::KindLsb];
	assign r_kind = req.record_handle[bshc_pkg::KindMsb:bshc_pkg::KindLsb];
	assign s_life = req.slice_handle[bshc_pkg::LifeMsb:bshc_pkg::LifeLsb];
	assign r_life = req.record_handle[bshc_pkg::LifeMsb:bshc_pkg::LifeLsb];

	always_comb begin
		if (!s_ok || !r_ok) begin
			status = bshc_pkg::ST_HANDLE;
		end else if ((s_kind != req.expected_kind) || (r_kind != req.expected_kind)) begin
			status = bshc_pkg::ST_KIND;
		end else if (req.slice_handle[bshc_pkg::SlotMsb:0] !=
				req.record_handle[bshc_pkg::SlotMsb:0]) begin
			status = bshc_pkg::ST_SLOT;
		end else if (req.slice_handle[bshc_pkg::GenMsb:bshc_pkg::GenLsb] !=
				req.record_handle[bshc_pkg::GenMsb:bshc_pkg::GenLsb]) begin
			status = bshc_pkg::ST_STALE;
		end else if (s_life != r_life) begin
			status = bshc_pkg::ST_LIFETIME;
		end else if ((r_life == cfg.life_last) &&
				(req.record_frame != req.current_frame)) begin
			status = bshc_pkg::ST_EXPIRED;
		end else if (req.slice_size == 32'd0) begin
			status = bshc_pkg::ST_EMPTY;
		end else if ((req.slice_offset > req.record_capacity) ||
				(req.slice_size > (req.record_capacity - req.slice_offset))) begin
			status = bshc_pkg::ST_OVERFLOW;
		end else begin
			status = bshc_pkg::ST_VALID;
		end
	end

endmodule

// ===== hw/rtl/buffer_slice_handle_checker_top.sv =====
// Top level of the buffer slice handle checker: stream ports, register port,
// input and result registers. Depends on bshc_pkg and bshc_eval.
//
// Each transaction on the slave stream carries one slice request together with
// its buffer record; the block answers each with exactly one status code on the
// master stream, in order. A request is latched into an input register, checked
// by one pass of compare logic and the result is held in an output register,
// from which its status is offered on the master stream. One request is
// taken every cycle as long as the receiver takes results.
// When the receiver stalls, the output register holds its status and the input
// register can still take one more request; s_tready falls only when both hold
// data. The four range registers sit behind the APB port at byte addresses 0, 4,
// 8 and 12; they should be written only while no transaction is in flight.
// Reset empties both registers and restores the default kind range 0 to 3 and
// lifetime range 0 to 2.
module buffer_slice_handle_checker_top (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      s_tvalid,
	output logic                                      s_tready,
	// slice_handle, slice_offset, slice_size, record_handle, record_capacity,
	// record_frame, expected_kind, current_frame
	input  logic [bshc_pkg::InTdataWidth-1:0]         s_tdata,
	output logic                                      m_tvalid,
	input  logic                                      m_tready,
	// status, then zero padding
	output logic [bshc_pkg::OutTdataWidth-1:0]        m_tdata,
	input  logic                                      psel,
	input  logic                                      penable,
	input  logic                                      pwrite,
	input  logic [bshc_pkg::PaddrWidth-1:0]           paddr,
	input  logic [31:0]                               pwdata,
	output logic [31:0]                               prdata,
	output logic                                      pready
);

	bshc_pkg::cfg_t    cfg_q;
	bshc_pkg::req_t    req_s1;
	logic              valid_s1;
	bshc_pkg::status_t status_s2;
	bshc_pkg::status_t status_next;
	logic              valid_s2;
	logic              adv_s2;
	logic              adv_s1;
	logic              cfg_wr;
	logic [1:0]        reg_sel;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_sel = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kind_first <= bshc_pkg::KindFirstReset;
			cfg_q.kind_last  <= bshc_pkg::KindLastReset;
			cfg_q.life_first <= bshc_pkg::LifeFirstReset;
			cfg_q.life_last  <= bshc_pkg::LifeLastReset;
		end else if (cfg_wr) begin
			case (reg_sel)
				bshc_pkg::RegKindFirst: cfg_q.kind_first <= pwdata[7:0];
				bshc_pkg::RegKindLast:  cfg_q.kind_last  <= pwdata[7:0];
				bshc_pkg::RegLifeFirst: cfg_q.life_first <= pwdata[3:0];
				bshc_pkg::RegLifeLast:  cfg_q.life_last  <= pwdata[3:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			bshc_pkg::RegKindFirst: prdata = {24'd0, cfg_q.kind_first};
			bshc_pkg::RegKindLast:  prdata = {24'd0, cfg_q.kind_last};
			bshc_pkg::RegLifeFirst: prdata = {28'd0, cfg_q.life_first};
			bshc_pkg::RegLifeLast:  prdata = {28'd0, cfg_q.life_last};
			default:                prdata = 32'd0;
		endcase
	end

	assign adv_s2   = !valid_s2 || m_tready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign s_tready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= s_tvalid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && s_tvalid) begin
			req_s1 <= bshc_pkg::req_t'(s_tdata);
		end
		if (adv_s2 && valid_s1) begin
			status_s2 <= status_next;
		end
	end

	bshc_eval u_eval (
		.req    (req_s1),
		.cfg    (cfg_q),
		.status (status_next)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(bshc_pkg::OutTdataWidth - $bits(status_s2)){1'b0}}, status_s2};

endmodule

// ===== hw/rtl/bshc_checker.sv =====
// Port checker for the buffer slice handle checker, bound to the top level.
// Depends on buffer_slice_handle_checker_top_assert.svh for its macros.
`include "buffer_slice_handle_checker_top_assert.svh"

module bshc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata
);

	logic out_stalled;
	logic code_ok;
	logic in_hs;

	assign out_stalled = m_tvalid && !m_tready;
	assign code_ok     = (m_tdata[7:4] == 4'd0) && (!m_tdata[3] || (m_tdata[2:0] == 3'd0));
	assign in_hs       = s_tvalid && s_tready;

	`BSHC_ASSERT_NEXT(a_out_hold, out_stalled, m_tvalid && $stable(m_tdata), "held result changed")
	`BSHC_ASSERT_SAME(a_status_code, m_tvalid, code_ok, "status code out of range")
	`BSHC_ASSERT_SAME(a_stall_only_full, !s_tready, m_tvalid, "input stalled with empty output")
	`BSHC_ASSERT_SAME(a_rise_latency, $rose(m_tvalid), $past(in_hs, 2), "result without request")

endmodule

bind buffer_slice_handle_checker_top bshc_checker u_bshc_checker (.*);

// ===== tb/sv/bshc_status_monitor.sv =====
`timescale 1ns / 100ps
// Status monitor for the buffer slice handle checker: follows the range registers on the APB
// port, predicts the status of each accepted request and compares it with the result stream.
// Depends on bshc_pkg.
module bshc_status_monitor
	import bshc_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	input  logic                     s_tready,
	input  logic [InTdataWidth-1:0]  s_tdata,
	input  logic                     m_tvalid,
	input  logic                     m_tready,
	input  logic [OutTdataWidth-1:0] m_tdata,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [PaddrWidth-1:0]    paddr,
	input  logic [31:0]              pwdata,
	input  logic                     pready,
	output int                       errors,
	output int                       outstanding
);

	cfg_t    range_cfg;
	status_t status_queue[$];
	status_t want_status;
	logic [3:0] got_status;
	int mismatches = 0;

	assign errors = mismatches;

	function automatic logic handle_usable(input logic [63:0] h, input cfg_t c);
		logic [7:0] kind;
		logic [3:0] life;
		kind = h[KindMsb:KindLsb];
		life = h[LifeMsb:LifeLsb];
		if (h[63:RsvdLsb] != '0 || h[SlotMsb:0] == '0 || h[GenMsb:GenLsb] == '0)
			return 1'b0;
		return kind >= c.kind_first && kind <= c.kind_last &&
			life >= c.life_first && life <= c.life_last;
	endfunction

	function automatic status_t predict_status(input req_t r, input cfg_t c);
		logic [63:0] sh;
		logic [63:0] rh;
		sh = r.slice_handle;
		rh = r.record_handle;
		if (!handle_usable(sh, c) || !handle_usable(rh, c))
			return ST_HANDLE;
		if (sh[KindMsb:KindLsb] != r.expected_kind || rh[KindMsb:KindLsb] != r.expected_kind)
			return ST_KIND;
		if (sh[SlotMsb:0] != rh[SlotMsb:0])
			return ST_SLOT;
		if (sh[GenMsb:GenLsb] != rh[GenMsb:GenLsb])
			return ST_STALE;
		if (sh[LifeMsb:LifeLsb] != rh[LifeMsb:LifeLsb])
			return ST_LIFETIME;
		if (rh[LifeMsb:LifeLsb] == c.life_last && r.record_frame != r.current_frame)
			return ST_EXPIRED;
		if (r.slice_size == '0)
			return ST_EMPTY;
		if (r.slice_offset > r.record_capacity ||
			r.slice_size > r.record_capacity - r.slice_offset)
			return ST_OVERFLOW;
		return ST_VALID;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_cfg <= '{KindFirstReset, KindLastReset, LifeFirstReset, LifeLastReset};
			status_queue.delete();
			outstanding <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_status = m_tdata[3:0];
				if (status_queue.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected status transaction, expected none, actual %0d",
						$time, got_status);
				end else begin
					want_status = status_queue.pop_front();
					if (got_status != want_status) begin
						mismatches++;
						$display("%0t: status mismatch, expected %0d (%s), actual %0d",
							$time, want_status, want_status.name(), got_status);
					end
				end
			end
			if (s_tvalid && s_tready)
				status_queue.push_back(predict_status(req_t'(s_tdata), range_cfg));
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					RegKindFirst: range_cfg.kind_first <= pwdata[7:0];
					RegKindLast:  range_cfg.kind_last  <= pwdata[7:0];
					RegLifeFirst: range_cfg.life_first <= pwdata[3:0];
					RegLifeLast:  range_cfg.life_last  <= pwdata[3:0];
					default: ;
				endcase
			end
			outstanding <= status_queue.size();
		end
	end

endmodule

// ===== tb/sv/tb_buffer_slice_handle_checker_top.sv =====
`timescale 1ns / 100ps
// Testbench top for the buffer slice handle checker: clock, reset, range register writes,
// request stimulus and result back-pressure. Depends on bshc_pkg and bshc_status_monitor.
module tb_buffer_slice_handle_checker_top;
	import bshc_pkg::*;

	typedef enum int {
		MK_VALID, MK_BAD_HANDLE, MK_KIND, MK_SLOT, MK_STALE,
		MK_LIFETIME, MK_EXPIRED, MK_EMPTY, MK_OVERFLOW, MK_NOISE
	} shape_t;

	typedef enum int {
		BAD_ZERO, BAD_RESERVED, BAD_SLOT, BAD_GEN, BAD_KIND, BAD_LIFE
	} bad_part_t;

	typedef struct packed {
		logic [3:0]  rsvd;
		logic [3:0]  life;
		logic [7:0]  kind;
		logic [23:0] gen;
		logic [23:0] slot;
	} handle_t;

	localparam int QuietLimit = 5000;
	localparam int HoldCycles = 64;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     s_tvalid = 1'b0;
	logic                     s_tready;
	logic [InTdataWidth-1:0]  s_tdata = '0;
	logic                     m_tvalid;
	logic                     m_tready = 1'b0;
	logic [OutTdataWidth-1:0] m_tdata;
	logic                     psel = 1'b0;
	logic                     penable = 1'b0;
	logic                     pwrite = 1'b0;
	logic [PaddrWidth-1:0]    paddr = '0;
	logic [31:0]              pwdata = '0;
	logic [31:0]              prdata;
	logic                     pready;

	int   fail_count;
	int   outstanding;
	int   stall_pct = 0;
	logic hold_req = 1'b0;
	int   hold_left = 0;
	int   quiet = 0;

	logic [7:0] kind_lo = KindFirstReset;
	logic [7:0] kind_hi = KindLastReset;
	logic [3:0] life_lo = LifeFirstReset;
	logic [3:0] life_hi = LifeLastReset;

	buffer_slice_handle_checker_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	bshc_status_monitor status_mon (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.errors(fail_count), .outstanding(outstanding)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// The long hold-off is counted here so that the sender keeps offering meanwhile.
	always @(posedge clk) begin
		if (hold_req)
			hold_left = HoldCycles;
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
			quiet = 0;
		else
			quiet++;
		if (quiet >= QuietLimit) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic shape_t pick_shape();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 15)
			return MK_NOISE;
		if (roll < 35)
			return MK_VALID;
		return shape_t'($urandom_range(MK_BAD_HANDLE, MK_OVERFLOW));
	endfunction

	// Builds a matching slice and record for the current ranges, then breaks the part that
	// the shape names; the noise shape instead randomises most of the fields.
	function automatic req_t build_request(input shape_t shape);
		handle_t     sh;
		handle_t     rh;
		req_t        r;
		logic [31:0] cap;
		logic [23:0] v;
		logic [7:0]  k2;
		logic [3:0]  l2;
		sh.rsvd = '0;
		sh.slot = 24'($urandom_range(1, 24'hffffff));
		sh.gen  = 24'($urandom_range(1, 24'hffffff));
		sh.kind = 8'($urandom_range(kind_lo, kind_hi));
		sh.life = 4'($urandom_range(life_lo, life_hi));
		rh = sh;
		r.expected_kind = sh.kind;
		r.current_frame = rand64();
		r.record_frame = $urandom_range(0, 1) ? r.current_frame : rand64();
		if (rh.life == life_hi)
			r.record_frame = r.current_frame;
		if ($urandom_range(0, 3) == 0)
			cap = $urandom_range(1, 64);
		else
			cap = $urandom_range(1, 32'hffffffff);
		r.record_capacity = cap;
		r.slice_offset = $urandom_range(0, cap - 1);
		r.slice_size = $urandom_range(1, cap - r.slice_offset);
		case (shape)
			MK_BAD_HANDLE: begin
				case (bad_part_t'($urandom_range(BAD_ZERO, BAD_LIFE)))
					BAD_ZERO:     sh = '0;
					BAD_RESERVED: sh.rsvd = 4'($urandom_range(1, 15));
					BAD_SLOT:     sh.slot = '0;
					BAD_GEN:      sh.gen = '0;
					BAD_KIND: begin
						if (kind_hi < 8'hff)
							sh.kind = 8'($urandom_range(kind_hi + 1, 255));
						else if (kind_lo > 0)
							sh.kind = 8'($urandom_range(0, kind_lo - 1));
					end
					default: begin
						if (life_hi < 4'hf)
							sh.life = 4'($urandom_range(life_hi + 1, 15));
						else if (life_lo > 0)
							sh.life = 4'($urandom_range(0, life_lo - 1));
					end
				endcase
				if ($urandom_range(0, 1))
					{sh, rh} = {rh, sh};
			end
			MK_KIND: begin
				if (kind_hi > kind_lo && $urandom_range(0, 1)) begin
					do k2 = 8'($urandom_range(kind_lo, kind_hi)); while (k2 == sh.kind);
					if ($urandom_range(0, 1))
						rh.kind = k2;
					else
						sh.kind = k2;
				end else begin
					r.expected_kind = sh.kind + 8'($urandom_range(1, 255));
				end
			end
			MK_SLOT: begin
				do v = 24'($urandom_range(1, 24'hffffff)); while (v == sh.slot);
				rh.slot = v;
			end
			MK_STALE: begin
				do v = 24'($urandom_range(1, 24'hffffff)); while (v == sh.gen);
				rh.gen = v;
			end
			MK_LIFETIME: begin
				if (life_hi > life_lo) begin
					do l2 = 4'($urandom_range(life_lo, life_hi)); while (l2 == sh.life);
					rh.life = l2;
				end
			end
			MK_EXPIRED: begin
				sh.life = life_hi;
				rh.life = life_hi;
				do r.record_frame = rand64(); while (r.record_frame == r.current_frame);
			end
			MK_EMPTY: begin
				r.slice_size = '0;
				r.slice_offset = $urandom_range(0, 1) ? $urandom : $urandom_range(0, cap);
			end
			MK_OVERFLOW: begin
				if (cap < 32'hffffffff && $urandom_range(0, 1)) begin
					r.slice_offset = $urandom_range(cap + 1, 32'hffffffff);
					r.slice_size = $urandom_range(1, 32'hffffffff);
				end else begin
					r.slice_offset = $urandom_range(0, cap);
					if (cap - r.slice_offset == 32'hffffffff)
						r.slice_offset = 1;
					r.slice_size = $urandom_range(cap - r.slice_offset + 1, 32'hffffffff);
				end
			end
			MK_NOISE: begin
				r.slice_offset = $urandom;
				r.slice_size = $urandom;
				r.record_capacity = $urandom;
				r.expected_kind = 8'($urandom);
				r.record_frame = rand64();
				if ($urandom_range(0, 1)) begin
					sh = rand64();
					rh = rand64();
				end
			end
			default: ;
		endcase
		r.slice_handle = sh;
		r.record_handle = rh;
		return r;
	endfunction

	task automatic send_request(input req_t r, input int idle_pct);
		while ($urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= r;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic run_random(input int count, input int idle_pct);
		repeat (count) send_request(build_request(pick_shape()), idle_pct);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_ranges(input logic [7:0] k_lo, input logic [7:0] k_hi,
		input logic [3:0] l_lo, input logic [3:0] l_hi);
		write_reg(RegKindFirst, 32'(k_lo));
		write_reg(RegKindLast, 32'(k_hi));
		write_reg(RegLifeFirst, 32'(l_lo));
		write_reg(RegLifeLast, 32'(l_hi));
		kind_lo = k_lo;
		kind_hi = k_hi;
		life_lo = l_lo;
		life_hi = l_hi;
	endtask

	initial begin
		req_t bound_req;
		logic [7:0] k_lo;
		logic [3:0] l_lo;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request('0, 0);
		send_request('1, 0);
		for (int s = MK_VALID; s <= MK_OVERFLOW; s++)
			repeat (2) send_request(build_request(shape_t'(s)), 0);
		bound_req = build_request(MK_VALID);
		bound_req.record_capacity = 32'hffffffff;
		bound_req.slice_offset = '0;
		bound_req.slice_size = 32'hffffffff;
		send_request(bound_req, 0);
		bound_req = build_request(MK_VALID);
		bound_req.slice_offset = bound_req.record_capacity;
		bound_req.slice_size = 1;
		send_request(bound_req, 0);
		run_random(70, 0);
		drain();

		set_ranges(8'd0, 8'd255, 4'd0, 4'd15);
		run_random(90, 82);
		drain();

		stall_pct = 82;
		set_ranges(8'd255, 8'd255, 4'd15, 4'd15);
		run_random(90, 0);
		drain();

		stall_pct = 9;
		set_ranges(8'd0, 8'd0, 4'd0, 4'd0);
		run_random(90, 9);
		drain();

		stall_pct = 0;
		set_ranges(8'd200, 8'd10, 4'd12, 4'd3);
		run_random(40, 0);
		drain();

		k_lo = 8'($urandom_range(0, 200));
		l_lo = 4'($urandom_range(0, 12));
		set_ranges(k_lo, 8'($urandom_range(k_lo, 255)), l_lo, 4'($urandom_range(l_lo, 15)));
		hold_req <= 1'b1;
		@(posedge clk);
		hold_req <= 1'b0;
		run_random(90, 0);
		drain();

		stall_pct = 82;
		set_ranges(8'd1, 8'd3, 4'd1, 4'd3);
		run_random(60, 82);
		drain();

		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
